// File: rtl/core/act_sel_pkg.sv
// Package for the activity selection sorter: sizes, buffer entry type and sequencer states.
// No dependencies. Used by the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package act_sel_pkg;

  localparam int MAX_ACT = 32;
  localparam int TIME_W  = 16;
  localparam int TOTAL_W = 6;
  localparam int IDX_W   = $clog2(MAX_ACT);
  localparam int CNT_W   = $clog2(MAX_ACT + 1);
  // run bounds reach lo + 2*width, which stays below 3 * MAX_ACT
  localparam int PTR_W   = CNT_W + 2;

  typedef struct packed {
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] finish;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PASS_CHK,
    ST_RUN_SET,
    ST_MRG_RD,
    ST_MRG_WR,
    ST_SEL_RD,
    ST_SEL_CHK,
    ST_SEL_FLUSH
  } seq_state_t;

endpackage

`default_nettype wire

// File: rtl/core/act_sel_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module act_sel_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr_a,
  input  wire logic [ADDR_W-1:0] raddr_b,
  output logic      [DATA_W-1:0] rdata_a,
  output logic      [DATA_W-1:0] rdata_b
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// File: rtl/core/activity_selection_sorter_top.sv
// Activity selection block: loads (start, finish) pairs one beat per cycle. After the beat
// marked last it merge-sorts the stored set by finish time (stable) through two ping-pong
// buffer RAMs, then makes one greedy pass and sends one result beat per chosen activity.
// Loading beats are taken one per cycle; a beat beyond MAX_ACT items is dropped and flagged.
// After the last beat, in_stall stays high until the final result beat enters the output
// register. Each merged or scanned element takes a read state and a compare state (which
// also writes when merging) on the buffer RAM, whose read is registered. Result beats are
// held in an output register, so the next run can load while the final result waits.
// Depends on act_sel_pkg and act_sel_ram.
`timescale 1ns / 1ps
`default_nettype none

module activity_selection_sorter_top
  import act_sel_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [TIME_W-1:0]  in_start_time,
  input  wire logic [TIME_W-1:0]  in_finish_time,
  input  wire logic               in_is_last_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic      [TIME_W-1:0]  out_chosen_start,
  output logic      [TIME_W-1:0]  out_chosen_finish,
  output logic      [TOTAL_W-1:0] out_chosen_total,
  output logic                    out_overflow,
  output logic                    out_is_last_result
);

  seq_state_t state_r, state_nxt;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              ovf_r, ovf_nxt;
  logic              src_r, src_nxt;
  logic [PTR_W-1:0]  width_r, width_nxt;
  logic [PTR_W-1:0]  lo_r, lo_nxt;
  logic [PTR_W-1:0]  mid_r, mid_nxt;
  logic [PTR_W-1:0]  hi_r, hi_nxt;
  logic [PTR_W-1:0]  i_r, i_nxt;
  logic [PTR_W-1:0]  j_r, j_nxt;
  logic [PTR_W-1:0]  k_r, k_nxt;
  logic [CNT_W-1:0]  tot_r, tot_nxt;
  logic              pend_vld_r, pend_vld_nxt;
  entry_t            pend_r, pend_nxt;
  logic [TIME_W-1:0] last_fin_r, last_fin_nxt;

  logic              out_vld_r, out_vld_nxt;
  entry_t            out_ent_r, out_ent_nxt;
  logic [CNT_W-1:0]  out_tot_r, out_tot_nxt;
  logic              out_ovf_r, out_ovf_nxt;
  logic              out_last_r, out_last_nxt;

  logic             b0_we, b1_we;
  logic [IDX_W-1:0] b0_waddr, b1_waddr;
  entry_t           b0_wdata, b1_wdata;
  logic [IDX_W-1:0] raddr_a, raddr_b;
  entry_t           b0_rd_a, b0_rd_b, b1_rd_a, b1_rd_b;
  entry_t           rd_a, rd_b;

  logic             in_acc;
  logic             out_free;
  logic [PTR_W-1:0] n_ext;
  logic [PTR_W-1:0] lo_plus_w, lo_plus_2w;
  logic             take_j;
  logic             chosen;

  act_sel_ram #(.DATA_W(ENTRY_W), .DEPTH(MAX_ACT)) u_buf0 (
    .clk     (clk),
    .we      (b0_we),
    .waddr   (b0_waddr),
    .wdata   (b0_wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (b0_rd_a),
    .rdata_b (b0_rd_b)
  );

  act_sel_ram #(.DATA_W(ENTRY_W), .DEPTH(MAX_ACT)) u_buf1 (
    .clk     (clk),
    .we      (b1_we),
    .waddr   (b1_waddr),
    .wdata   (b1_wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (b1_rd_a),
    .rdata_b (b1_rd_b)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_vld_r || !out_stall;
  assign n_ext    = PTR_W'(count_r);
  assign rd_a     = src_r ? b1_rd_a : b0_rd_a;
  assign rd_b     = src_r ? b1_rd_b : b0_rd_b;
  assign lo_plus_w  = lo_r + width_r;
  assign lo_plus_2w = lo_r + (width_r << 1);
  // left run empty, or right run still has items and a strictly smaller finish
  assign take_j   = (i_r >= mid_r) || ((j_r < hi_r) && (rd_a.finish > rd_b.finish));
  assign chosen   = (k_r == '0) || (rd_a.start > last_fin_r);

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    ovf_nxt      = ovf_r;
    src_nxt      = src_r;
    width_nxt    = width_r;
    lo_nxt       = lo_r;
    mid_nxt      = mid_r;
    hi_nxt       = hi_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    tot_nxt      = tot_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    last_fin_nxt = last_fin_r;
    out_vld_nxt  = out_vld_r && out_stall;
    out_ent_nxt  = out_ent_r;
    out_tot_nxt  = out_tot_r;
    out_ovf_nxt  = out_ovf_r;
    out_last_nxt = out_last_r;
    b0_we        = 1'b0;
    b1_we        = 1'b0;
    b0_waddr     = k_r[IDX_W-1:0];
    b1_waddr     = k_r[IDX_W-1:0];
    b0_wdata     = take_j ? rd_b : rd_a;
    b1_wdata     = take_j ? rd_b : rd_a;
    raddr_a      = i_r[IDX_W-1:0];
    raddr_b      = j_r[IDX_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        b0_waddr = count_r[IDX_W-1:0];
        b0_wdata = '{start: in_start_time, finish: in_finish_time};
        if (in_acc) begin
          if (count_r < CNT_W'(MAX_ACT)) begin
            b0_we     = 1'b1;
            count_nxt = count_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_is_last_item) begin
            src_nxt   = 1'b0;
            width_nxt = PTR_W'(1);
            state_nxt = ST_PASS_CHK;
          end
        end
      end
      ST_PASS_CHK: begin
        if (width_r < n_ext) begin
          lo_nxt    = '0;
          state_nxt = ST_RUN_SET;
        end else begin
          k_nxt        = '0;
          tot_nxt      = '0;
          pend_vld_nxt = 1'b0;
          state_nxt    = ST_SEL_RD;
        end
      end
      ST_RUN_SET: begin
        if (lo_r < n_ext) begin
          mid_nxt   = (lo_plus_w > n_ext) ? n_ext : lo_plus_w;
          hi_nxt    = (lo_plus_2w > n_ext) ? n_ext : lo_plus_2w;
          i_nxt     = lo_r;
          j_nxt     = (lo_plus_w > n_ext) ? n_ext : lo_plus_w;
          k_nxt     = lo_r;
          state_nxt = ST_MRG_RD;
        end else begin
          width_nxt = width_r << 1;
          src_nxt   = !src_r;
          state_nxt = ST_PASS_CHK;
        end
      end
      ST_MRG_RD: begin
        if (k_r >= hi_r) begin
          lo_nxt    = hi_r;
          state_nxt = ST_RUN_SET;
        end else begin
          state_nxt = ST_MRG_WR;
        end
      end
      ST_MRG_WR: begin
        b0_we = src_r;
        b1_we = !src_r;
        k_nxt = k_r + 1'b1;
        if (take_j) begin
          j_nxt = j_r + 1'b1;
        end else begin
          i_nxt = i_r + 1'b1;
        end
        state_nxt = ST_MRG_RD;
      end
      ST_SEL_RD: begin
        raddr_a = k_r[IDX_W-1:0];
        if (k_r >= n_ext) begin
          state_nxt = ST_SEL_FLUSH;
        end else begin
          state_nxt = ST_SEL_CHK;
        end
      end
      ST_SEL_CHK: begin
        raddr_a = k_r[IDX_W-1:0];
        if (!chosen) begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_SEL_RD;
        end else if (!pend_vld_r || out_free) begin
          // the held choice goes out now that a later one exists
          if (pend_vld_r) begin
            out_vld_nxt  = 1'b1;
            out_ent_nxt  = pend_r;
            out_tot_nxt  = '0;
            out_ovf_nxt  = ovf_r;
            out_last_nxt = 1'b0;
          end
          pend_vld_nxt = 1'b1;
          pend_nxt     = rd_a;
          last_fin_nxt = rd_a.finish;
          tot_nxt      = tot_r + 1'b1;
          k_nxt        = k_r + 1'b1;
          state_nxt    = ST_SEL_RD;
        end
      end
      ST_SEL_FLUSH: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_ent_nxt  = pend_r;
          out_tot_nxt  = tot_r;
          out_ovf_nxt  = ovf_r;
          out_last_nxt = 1'b1;
          pend_vld_nxt = 1'b0;
          count_nxt    = '0;
          ovf_nxt      = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      count_r    <= '0;
      ovf_r      <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      last_fin_r <= '0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      ovf_r      <= ovf_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      last_fin_r <= last_fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r      <= src_nxt;
    width_r    <= width_nxt;
    lo_r       <= lo_nxt;
    mid_r      <= mid_nxt;
    hi_r       <= hi_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    tot_r      <= tot_nxt;
    pend_r     <= pend_nxt;
    out_ent_r  <= out_ent_nxt;
    out_tot_r  <= out_tot_nxt;
    out_ovf_r  <= out_ovf_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid          = out_vld_r;
  assign out_chosen_start   = out_ent_r.start;
  assign out_chosen_finish  = out_ent_r.finish;
  assign out_chosen_total   = TOTAL_W'(out_tot_r);
  assign out_overflow       = out_ovf_r;
  assign out_is_last_result = out_last_r;

endmodule

`default_nettype wire

// File: rtl/core/act_sel_checker.sv
// Port-level checker for the activity selection sorter, bound to the top level.
// Depends on act_sel_pkg.
`timescale 1ns / 1ps
`default_nettype none

module act_sel_assert
  import act_sel_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               in_is_last_item,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [TIME_W-1:0]  out_chosen_start,
  input wire logic [TIME_W-1:0]  out_chosen_finish,
  input wire logic [TOTAL_W-1:0] out_chosen_total,
  input wire logic               out_is_last_result
);

  // a held result beat does not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_chosen_start)
      && $stable(out_chosen_finish) && $stable(out_is_last_result))
    else $error("stalled result beat changed");

  // total only on the closing beat, and never zero there
  a_total_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_last_result |-> out_chosen_total == '0)
    else $error("total on a non-final result beat");

  a_total_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_last_result |-> out_chosen_total != '0)
    else $error("zero total on final result beat");

  // closing input beat starts the sort, so input stalls straight after
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_is_last_item |=> in_stall)
    else $error("input not stalled after last beat");

  // while a run is still emitting, no new beat is taken
  a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_last_result |-> in_stall)
    else $error("input taken mid-run");

endmodule

bind activity_selection_sorter_top act_sel_assert u_act_sel_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .in_is_last_item    (in_is_last_item),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_chosen_start   (out_chosen_start),
  .out_chosen_finish  (out_chosen_finish),
  .out_chosen_total   (out_chosen_total),
  .out_is_last_result (out_is_last_result)
);

`default_nettype wire
